// ----- sv/gcsi_pkg.sv -----
// ---------------------------------------------------------------------------
// Gas cell safety interlock package
// Shared item types, register indexes, frame header bytes and reset values.
// ---------------------------------------------------------------------------
package gcsi_pkg;

	// One input beat: a link byte with the pressure and power sense that
	// go with it.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic [7:0] pressure_bar;
		logic       power_feedback;
	} in_item_t;

	// One result beat.
	typedef struct packed {
		logic        command_issued;
		logic        power_level;
		logic        frame_valid;
		logic [15:0] concentration_out;
		logic [15:0] flow_out;
		logic [15:0] temperature_out;
	} result_t;

	// A parsed beat handed from the front to the back.
	typedef struct packed {
		logic        complete;
		logic [15:0] concentration;
		logic [15:0] flow;
		logic [15:0] temperature;
		logic [7:0]  pressure_bar;
		logic        power_feedback;
	} parsed_t;

	// Threshold registers.
	typedef struct packed {
		logic [15:0] concentration_low_limit;
		logic [15:0] flow_high_limit;
		logic [15:0] flow_low_limit;
		logic [15:0] temperature_high_limit;
		logic [7:0]  pressure_high_limit;
	} cfg_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_CONC_LOW  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FLOW_HIGH = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FLOW_LOW  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TEMP_HIGH = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_PRES_HIGH = 3'd4;

	localparam logic [15:0] CONC_LOW_RESET  = 16'd200;
	localparam logic [15:0] FLOW_HIGH_RESET = 16'd50;
	localparam logic [15:0] FLOW_LOW_RESET  = 16'd1;
	localparam logic [15:0] TEMP_HIGH_RESET = 16'd600;
	localparam logic [7:0]  PRES_HIGH_RESET = 8'd5;

	localparam logic [7:0] HDR0 = 8'h16;
	localparam logic [7:0] HDR1 = 8'h09;
	localparam logic [7:0] HDR2 = 8'h01;

	// Frame positions: 0..2 header, 3..8 payload bytes.
	localparam logic [3:0] POS_HUNT          = 4'd0;
	localparam logic [3:0] POS_HDR1          = 4'd1;
	localparam logic [3:0] POS_HDR2          = 4'd2;
	localparam logic [3:0] POS_PAYLOAD_FIRST = 4'd3;
	localparam logic [3:0] POS_FRAME_LAST    = 4'd8;

	// Payload bytes held before the last one arrives.
	localparam int unsigned HELD_BYTES = 5;

endpackage

// ----- sv/gas_cell_safety_interlock.sv -----
// ---------------------------------------------------------------------------
// Gas cell safety interlock
// Sensor link frame parser with threshold rules for the electrode relay.
// ---------------------------------------------------------------------------
// The block takes one beat per link byte, together with the tank pressure in
// whole bar and the electrode power sense, and returns exactly one result
// beat for each input beat, in order. It hunts for the header 16 09 01 and
// then gathers concentration, flow and temperature as big-endian 16-bit
// words; a frame with nonzero temperature is valid and runs the threshold
// rules against the previous valid frame. The pressure rule is checked on
// every beat against the last valid flow. The block takes one beat per
// clock cycle while the middle queue has room. Each beat is written into
// the queue between the parser and the rule stage, waits there while the
// rules are worked out, and is then written into the result queue, from
// which the consumer pops it at the result ports. The front end stalls
// only when the middle queue is full, and the rule stage only when the
// result queue is full, so both sides can idle or stall independently
// without loss. The user must write the threshold registers through the
// configuration port only while the block is idle; the block itself does
// not enforce this. A write to an index beyond the register list is ignored.
// ---------------------------------------------------------------------------
module gas_cell_safety_interlock #(
	parameter int unsigned MID_DEPTH = 2,
	parameter int unsigned OUT_DEPTH = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input queue side.
	input  logic                                push,
	output logic                                full,
	input  gcsi_pkg::in_item_t                  sample,
	// Result queue side.
	output logic                                empty,
	input  logic                                pop,
	output gcsi_pkg::result_t                   result,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [gcsi_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [gcsi_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import gcsi_pkg::*;

	cfg_t    cfg_q;
	parsed_t parsed_front;
	parsed_t parsed_head;
	logic    mid_full;
	logic    mid_empty;
	logic    mid_pop;
	logic    accept;
	result_t result_back;
	logic    out_full;
	logic    out_push;

	// A beat is taken whenever the middle queue has room.
	assign full   = mid_full;
	assign accept = push && !mid_full;

	// Threshold registers, each written whole by its index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.concentration_low_limit <= CONC_LOW_RESET;
			cfg_q.flow_high_limit         <= FLOW_HIGH_RESET;
			cfg_q.flow_low_limit          <= FLOW_LOW_RESET;
			cfg_q.temperature_high_limit  <= TEMP_HIGH_RESET;
			cfg_q.pressure_high_limit     <= PRES_HIGH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CONC_LOW:  cfg_q.concentration_low_limit <= cfg_data;
				REG_FLOW_HIGH: cfg_q.flow_high_limit         <= cfg_data;
				REG_FLOW_LOW:  cfg_q.flow_low_limit          <= cfg_data;
				REG_TEMP_HIGH: cfg_q.temperature_high_limit  <= cfg_data;
				REG_PRES_HIGH: cfg_q.pressure_high_limit     <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Front end: header search and payload gathering, one byte per beat.
	gcsi_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (sample),
		.parsed (parsed_front)
	);

	// Middle queue decouples the parser from the rule stage.
	gcsi_fifo #(
		.WIDTH ($bits(parsed_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (parsed_front),
		.full      (mid_full),
		.pop       (mid_pop),
		.head      (parsed_head),
		.empty     (mid_empty)
	);

	// Back end: deltas, threshold rules and the pressure check.
	gcsi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.parsed       (parsed_head),
		.parsed_empty (mid_empty),
		.parsed_pop   (mid_pop),
		.result_full  (out_full),
		.result_push  (out_push),
		.result       (result_back)
	);

	// Result queue holds finished beats until the consumer pops them.
	gcsi_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (out_push),
		.push_data (result_back),
		.full      (out_full),
		.pop       (pop),
		.head      (result),
		.empty     (empty)
	);

endmodule

// ----- sv/gcsi_fifo.sv -----
// ---------------------------------------------------------------------------
// Gas cell safety interlock queue
// Small first-in first-out buffer of register entries with count tracking.
// ---------------------------------------------------------------------------
module gcsi_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/gcsi_front.sv -----
// ---------------------------------------------------------------------------
// Gas cell safety interlock front end
// Hunts for the frame header and gathers the six payload bytes.
// ---------------------------------------------------------------------------
module gcsi_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  gcsi_pkg::in_item_t item,
	output gcsi_pkg::parsed_t  parsed
);
	import gcsi_pkg::*;

	logic [3:0] pos_q;
	logic [3:0] pos_next;
	logic [7:0] held_q [HELD_BYTES];
	logic [3:0] held_offset;
	logic       in_payload;
	logic       at_last;

	assign in_payload  = (pos_q >= POS_PAYLOAD_FIRST) && (pos_q < POS_FRAME_LAST);
	assign at_last     = (pos_q == POS_FRAME_LAST);
	assign held_offset = pos_q - POS_PAYLOAD_FIRST;

	// A mismatch inside the header restarts at position one when the byte
	// could itself open a new header.
	always_comb begin
		priority if (pos_q == POS_HUNT) begin
			pos_next = (item.rx_byte == HDR0) ? POS_HDR1 : POS_HUNT;
		end else if (pos_q == POS_HDR1) begin
			pos_next = (item.rx_byte == HDR1) ? POS_HDR2 :
				((item.rx_byte == HDR0) ? POS_HDR1 : POS_HUNT);
		end else if (pos_q == POS_HDR2) begin
			pos_next = (item.rx_byte == HDR2) ? POS_PAYLOAD_FIRST :
				((item.rx_byte == HDR0) ? POS_HDR1 : POS_HUNT);
		end else if (in_payload) begin
			pos_next = pos_q + 4'd1;
		end else begin
			pos_next = POS_HUNT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
		end else if (accept) begin
			pos_q <= pos_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_payload) begin
			held_q[held_offset[2:0]] <= item.rx_byte;
		end
	end

	always_comb begin
		parsed.complete       = at_last;
		parsed.concentration  = {held_q[0], held_q[1]};
		parsed.flow           = {held_q[2], held_q[3]};
		parsed.temperature    = {held_q[4], item.rx_byte};
		parsed.pressure_bar   = item.pressure_bar;
		parsed.power_feedback = item.power_feedback;
	end

endmodule

// ----- sv/gcsi_back.sv -----
// ---------------------------------------------------------------------------
// Gas cell safety interlock back end
// Applies the threshold rules to parsed beats and builds the results.
// ---------------------------------------------------------------------------
module gcsi_back (
	input  logic              clk,
	input  logic              arst_n,
	input  gcsi_pkg::cfg_t    cfg,
	input  gcsi_pkg::parsed_t parsed,
	input  logic              parsed_empty,
	output logic              parsed_pop,
	input  logic              result_full,
	output logic              result_push,
	output gcsi_pkg::result_t result
);
	import gcsi_pkg::*;

	logic [15:0] prev_conc_q;
	logic [15:0] prev_flow_q;
	logic [15:0] prev_temp_q;
	logic        fire;
	logic        valid;
	logic [15:0] conc_delta;
	logic [15:0] flow_delta;
	logic [15:0] flow_now;
	logic        power;
	logic        cmd;

	assign fire        = !parsed_empty && !result_full;
	assign parsed_pop  = fire;
	assign result_push = fire;

	assign valid      = parsed.complete && (parsed.temperature != 16'd0);
	assign conc_delta = parsed.concentration - prev_conc_q;
	assign flow_delta = parsed.flow - prev_flow_q;
	// The last valid flow is this frame's flow when it is valid, else the stored flow of the previous valid frame.
	assign flow_now   = valid ? parsed.flow : prev_flow_q;

	always_comb begin
		power = parsed.power_feedback;
		cmd   = 1'b0;
		if (valid) begin
			if ((parsed.concentration < cfg.concentration_low_limit) && conc_delta[15]
				&& power) begin
				power = 1'b0;
				cmd   = 1'b1;
			end
			if (parsed.flow > cfg.flow_high_limit) begin
				if (power) begin
					power = 1'b0;
					cmd   = 1'b1;
				end
			end else if (parsed.flow < cfg.flow_low_limit) begin
				if (flow_delta[15] && !power) begin
					power = 1'b1;
					cmd   = 1'b1;
				end
			end
			if (parsed.temperature > cfg.temperature_high_limit) begin
				power = 1'b0;
				cmd   = 1'b1;
			end
		end
		if ((parsed.pressure_bar > cfg.pressure_high_limit) && (flow_now != 16'd0)) begin
			power = 1'b0;
			cmd   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_conc_q <= '0;
			prev_flow_q <= '0;
			prev_temp_q <= '0;
		end else if (fire && valid) begin
			prev_conc_q <= parsed.concentration;
			prev_flow_q <= parsed.flow;
			prev_temp_q <= parsed.temperature;
		end
	end

	always_comb begin
		result.command_issued    = cmd;
		result.power_level       = power;
		result.frame_valid       = valid;
		result.concentration_out = valid ? parsed.concentration : prev_conc_q;
		result.flow_out          = flow_now;
		result.temperature_out   = valid ? parsed.temperature : prev_temp_q;
	end

	// A valid frame always reports a nonzero temperature.
	a_valid_temp: assert property (@(posedge clk) disable iff (!arst_n)
		(result_push && result.frame_valid) |-> (result.temperature_out != 16'd0))
		else $error("valid frame with zero temperature");

	// Without a command the relay level follows the sensed power.
	a_no_cmd_level: assert property (@(posedge clk) disable iff (!arst_n)
		(result_push && !result.command_issued)
		|-> (result.power_level == parsed.power_feedback))
		else $error("power level changed without a command");

	// High pressure with flow present always ends with the power off.
	a_pressure_off: assert property (@(posedge clk) disable iff (!arst_n)
		(result_push && (parsed.pressure_bar > cfg.pressure_high_limit)
		&& (result.flow_out != 16'd0)) |-> (!result.power_level && result.command_issued))
		else $error("pressure rule did not switch power off");

	// Stored readings move only on a valid frame.
	a_prev_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && valid) |=> $stable(prev_flow_q) && $stable(prev_conc_q))
		else $error("stored readings moved without a valid frame");

endmodule
